/* design/stxrx_pkg.sv */
// Shared types, constants and the byte-wide CRC-32 step for the STX frame receiver.
`default_nettype none

package stxrx_pkg;

  localparam logic [7:0]  START_BYTE       = 8'h02;
  localparam logic [31:0] CRC_POLY_REFL    = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES     = 32'hFFFFFFFF;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd8000;
  localparam logic [15:0] CRC_BYTES        = 16'd4;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_GOOD     = 2'd1;
  localparam logic [1:0] KIND_BAD_CRC  = 2'd2;
  localparam logic [1:0] KIND_OVERSIZE = 2'd3;

  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_LEN_LO = 6'b000010,
    PH_LEN_HI = 6'b000100,
    PH_ID     = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_CRC    = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_id;
    logic [15:0] count;
  } result_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY_REFL;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

/* design/stxrx_parser.sv */
// Frame parser: phase machine, length and id capture, running CRC and status decision.
`default_nettype none

module stxrx_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [15:0]       max_length_i,
  output logic                   res_valid_o,
  output stxrx_pkg::result_t     res_o
);
  import stxrx_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] frame_length_q, frame_length_d;
  logic [15:0] byte_counter_q, byte_counter_d;
  logic [31:0] running_crc_q, running_crc_d;
  logic [31:0] received_crc_q, received_crc_d;
  logic [7:0]  current_id_q, current_id_d;

  logic [31:0] crc_seed;
  logic [31:0] crc_next;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;
  logic [31:0] rcrc_next;

  assign crc_seed  = (phase_q == PH_HUNT) ? CRC_ALL_ONES : running_crc_q;
  assign crc_next  = crc32_byte(crc_seed, rx_byte_i);
  assign cnt_inc   = byte_counter_q + 16'd1;
  assign len_full  = {rx_byte_i, frame_length_q[7:0]};
  assign rcrc_next = {rx_byte_i, received_crc_q[31:8]};

  always_comb begin
    phase_d        = phase_q;
    frame_length_d = frame_length_q;
    byte_counter_d = byte_counter_q;
    running_crc_d  = running_crc_q;
    received_crc_d = received_crc_q;
    current_id_d   = current_id_q;
    res_valid_o    = 1'b0;
    res_o          = '0;
    if (accept_i) begin
      unique case (phase_q)
        PH_LEN_LO: begin
          running_crc_d  = crc_next;
          frame_length_d = {8'd0, rx_byte_i};
          phase_d        = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          running_crc_d  = crc_next;
          frame_length_d = len_full;
          if (len_full > max_length_i) begin
            phase_d         = PH_HUNT;
            res_valid_o     = 1'b1;
            res_o.kind      = KIND_OVERSIZE;
            res_o.count     = len_full;
          end else begin
            phase_d = PH_ID;
          end
        end
        PH_ID: begin
          running_crc_d  = crc_next;
          current_id_d   = rx_byte_i;
          byte_counter_d = '0;
          received_crc_d = '0;
          phase_d        = (frame_length_q == 16'd0) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          running_crc_d   = crc_next;
          byte_counter_d  = cnt_inc;
          if (cnt_inc >= frame_length_q) begin
            byte_counter_d = '0;
            received_crc_d = '0;
            phase_d        = PH_CRC;
          end
          res_valid_o     = 1'b1;
          res_o.kind      = KIND_DATA;
          res_o.data_byte = rx_byte_i;
          res_o.frame_id  = current_id_q;
          res_o.count     = byte_counter_q;
        end
        PH_CRC: begin
          received_crc_d = rcrc_next;
          byte_counter_d = cnt_inc;
          if (cnt_inc >= CRC_BYTES) begin
            byte_counter_d = '0;
            phase_d        = PH_HUNT;
            res_valid_o    = 1'b1;
            res_o.kind     = ((running_crc_q ^ CRC_ALL_ONES) == rcrc_next) ?
                             KIND_GOOD : KIND_BAD_CRC;
            res_o.frame_id = current_id_q;
            res_o.count    = frame_length_q;
          end
        end
        default: begin
          phase_d = PH_HUNT;
          if (rx_byte_i == START_BYTE) begin
            running_crc_d  = crc_next;
            frame_length_d = '0;
            byte_counter_d = '0;
            received_crc_d = '0;
            current_id_d   = '0;
            phase_d        = PH_LEN_LO;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HUNT;
      frame_length_q <= '0;
      byte_counter_q <= '0;
      running_crc_q  <= CRC_ALL_ONES;
      received_crc_q <= '0;
      current_id_q   <= '0;
    end else begin
      phase_q        <= phase_d;
      frame_length_q <= frame_length_d;
      byte_counter_q <= byte_counter_d;
      running_crc_q  <= running_crc_d;
      received_crc_q <= received_crc_d;
      current_id_q   <= current_id_d;
    end
  end

endmodule

`default_nettype wire

/* design/stxrx_out_reg.sv */
// Output register holding one result beat until the consumer takes it.
`default_nettype none

module stxrx_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire stxrx_pkg::result_t res_i,
  input  wire logic               out_stall_i,
  output logic                    full_stall_o,
  output logic                    out_valid_o,
  output stxrx_pkg::result_t      res_o
);
  import stxrx_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign full_stall_o = valid_q && out_stall_i;
  assign valid_d      = push_i || (valid_q && out_stall_i);
  assign out_valid_o  = valid_q;
  assign res_o        = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

/* design/stx_length_crc32_frame_receiver_core.sv */
// Top level of the STX, length, id, payload and CRC-32 frame receiver.
//
//   Channel   Signals                                        Direction
//   config    max_length_we_i, max_length_i                  in
//   input     in_valid_i, in_stall_o, rx_byte_i               in
//   output    out_valid_o, out_stall_i, kind_o, data_byte_o,  out
//             frame_id_o, count_o
//
// One byte is taken every cycle unless the input is stalled; any result it
// yields is registered and appears in the cycle after the beat. The byte-wide
// CRC step and the phase machine sit between the parser state and the output
// register. Reset returns the parser to hunting and sets max_length to 8000.
// The input stalls only while a result is held and the output is stalled.
`default_nettype none

module stx_length_crc32_frame_receiver_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        max_length_we_i,
  input  wire logic [15:0] max_length_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       data_byte_o,
  output logic [7:0]       frame_id_o,
  output logic [15:0]      count_o
);
  import stxrx_pkg::*;

  logic [15:0] max_length_q;
  logic        in_accept;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LENGTH_RESET;
    end else if (max_length_we_i) begin
      max_length_q <= max_length_i;
    end
  end

  stxrx_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .rx_byte_i    (rx_byte_i),
    .max_length_i (max_length_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  stxrx_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (res_valid),
    .res_i        (res),
    .out_stall_i  (out_stall_i),
    .full_stall_o (in_stall_o),
    .out_valid_o  (out_valid_o),
    .res_o        (out_res)
  );

  assign kind_o      = out_res.kind;
  assign data_byte_o = out_res.data_byte;
  assign frame_id_o  = out_res.frame_id;
  assign count_o     = out_res.count;

`ifndef SYNTH
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("Input stalled with no result held.");

  a_status_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_DATA) |-> data_byte_o == 8'd0)
    else $error("Status beat carries a nonzero data byte.");

  a_oversize_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_OVERSIZE) |-> frame_id_o == 8'd0)
    else $error("Oversize status carries a frame id.");
`endif

endmodule

`default_nettype wire
